// ----- src/fts_pkg.sv -----
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants of the frame time window statistics block.
// ----------------------------------------------------------------------------
package fts_pkg;

  // history ring
  localparam int unsigned HistDepth = 256;
  localparam int unsigned AddrW     = $clog2(HistDepth);
  localparam int unsigned CntW      = $clog2(HistDepth + 1);

  // field widths
  localparam int unsigned TimeW = 20;
  localparam int unsigned PctW  = 14;
  localparam int unsigned RateW = 26;
  localparam int unsigned NumW  = 9;

  // accumulator and divider widths
  localparam int unsigned SumW  = TimeW + CntW;
  localparam int unsigned DivNW = (SumW > 27) ? SumW : 27;
  localparam int unsigned ProdW = PctW + CntW;

  // arithmetic constants
  localparam int unsigned RateNum     = 100000000;
  localparam int unsigned RateDefault = 6000;
  localparam int unsigned PctFull     = 10000;
  localparam int unsigned PctP99      = 9900;

  // rank = (p * (n - 1)) / 10000 as (x * RecipMul) >> RecipShift,
  // exact for every x below 2^22, which covers 10000 * 255
  localparam int unsigned RecipMul   = 6871948;
  localparam int unsigned RecipW     = 23;
  localparam int unsigned RecipShift = 36;

  // configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_BUDGET   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RECENT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CRIT_P99 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEGR_AVG = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPIKE    = 3'd4;

  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    WARN_NONE     = 2'd0,
    WARN_CRITICAL = 2'd1,
    WARN_DEGRADED = 2'd2,
    WARN_SPIKE    = 2'd3
  } warn_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TimeW-1:0] frame_time_us;
    logic [PctW-1:0]  percentile_hundredths;
  } req_t;

  typedef struct packed {
    logic [TimeW-1:0] min_time_us;
    logic [TimeW-1:0] max_time_us;
    logic [TimeW-1:0] mean_time_us;
    logic [RateW-1:0] recent_rate_centi_fps;
    logic [NumW-1:0]  over_budget_count;
    logic [TimeW-1:0] percentile_time_us;
    logic [1:0]       warning_code;
    logic [NumW-1:0]  entries_valid;
  } rsp_t;

endpackage

// ----- src/fts_div.sv -----
// ----------------------------------------------------------------------------
// fts_div
// Restoring divider, one quotient bit per cycle, shared by the mean,
// recent mean and rate divisions.
// ----------------------------------------------------------------------------
module fts_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fts_pkg::DivNW-1:0]   dividend_i,
  input  logic [fts_pkg::TimeW-1:0]   divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [fts_pkg::DivNW-1:0]   quot_o
);

  localparam int unsigned W  = fts_pkg::DivNW;
  localparam int unsigned DW = fts_pkg::TimeW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_q;
  logic [DW-1:0] rem_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   rem_sh, rem_sub;
  logic          ge;

  // one shift-subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[W-1]};
    ge      = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- src/frame_time_window_stats_top.sv -----
// ----------------------------------------------------------------------------
// frame_time_window_stats_top
// Ring history of frame times with min, max, mean, rolling rate,
// over-budget count, rank percentile and warning code on query.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_item_i) takes record,
//   query and clear items; every item gives exactly one result item on
//   the response channel (out_valid_o / out_stall_i / out_item_o).
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i;
//   the user must do so only while the block is idle, which the block does not enforce.
// Sequence:
//   Record, clear and reserved requests go straight to the done state,
//   from which the result is registered. A query on a non-empty ring
//   runs the statistics scan, the mean, recent mean and rate divisions
//   on the shared bit-serial divider and the bitwise rank selection,
//   which reads the history memory once per bit; a query on an empty
//   ring goes straight to the done state.
//   One item is in work at a time; in_stall_o is high until its result is
//   in the output register.
// Reset: ring empty, configuration at defaults; no clearing pass is needed
//   since only entries below the fill count are ever read.
// Stall: a held result stays in the output register; the next item may be
//   accepted, and its result waits until the register drains.
// ----------------------------------------------------------------------------
module frame_time_window_stats_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fts_pkg::req_t                 in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fts_pkg::rsp_t                 out_item_o,
  input  logic                          cfg_we_i,
  input  logic [fts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fts_pkg::TimeW-1:0]     cfg_wdata_i
);

  localparam int unsigned D     = fts_pkg::HistDepth;
  localparam int unsigned AW    = fts_pkg::AddrW;
  localparam int unsigned CW    = fts_pkg::CntW;
  localparam int unsigned TW    = fts_pkg::TimeW;
  localparam int unsigned SW    = fts_pkg::SumW;
  localparam int unsigned NW    = fts_pkg::DivNW;
  localparam int unsigned PW    = fts_pkg::ProdW;
  localparam int unsigned KW    = PW + fts_pkg::RecipW;
  localparam int unsigned BitCW = $clog2(TW);

  // state codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // divider operation codes
  localparam logic [2:0] OP_MEAN  = 3'd0;
  localparam logic [2:0] OP_RMEAN = 3'd1;
  localparam logic [2:0] OP_RATE  = 3'd2;

  // configuration registers
  logic [TW-1:0] budget_q, crit_q, degr_q, spike_q;
  logic [8:0]    recent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= TW'(16670);
      recent_q <= 9'd60;
      crit_q   <= TW'(25000);
      degr_q   <= TW'(17000);
      spike_q  <= TW'(50000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fts_pkg::CFG_BUDGET:   budget_q <= cfg_wdata_i;
        fts_pkg::CFG_RECENT:   recent_q <= cfg_wdata_i[8:0];
        fts_pkg::CFG_CRIT_P99: crit_q   <= cfg_wdata_i;
        fts_pkg::CFG_DEGR_AVG: degr_q   <= cfg_wdata_i;
        fts_pkg::CFG_SPIKE:    spike_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]    state_q;
  logic [AW-1:0] ws_q;
  logic [CW-1:0] valid_q;
  logic [CW-1:0] scan_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic          query_q;
  logic [2:0]    op_q;
  logic [BitCW-1:0] bit_q;
  logic          out_vld_q;

  // payload registers
  logic [TW-1:0]      rd_data_q;
  logic [TW-1:0]      min_q, max_q, mean_q, rmean_q, pa_q, pb_q;
  logic [SW-1:0]      sum_q, rsum_q;
  logic [CW-1:0]      over_q, s_q, cnta_q, cntb_q;
  logic [fts_pkg::PctW-1:0] pct_q;
  logic [PW-1:0]      prod_q, prod99_q;
  logic [NW-1:0]      rate_q;
  logic [AW-1:0]      ka_q, kb_q;
  fts_pkg::rsp_t      out_q;

  logic [TW-1:0] mem_q [D];

  logic accept;
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // history memory: record write, scan read
  logic mem_we;
  assign mem_we = accept && (in_item_i.req_type == fts_pkg::REQ_RECORD);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[ws_q] <= in_item_i.frame_time_us;
    rd_data_q <= mem_q[scan_q[AW-1:0]];
  end

  // scan sequencing
  logic issue, pass_end;
  assign issue    = ((state_q == S_SCAN) || (state_q == S_SEL)) && (scan_q < valid_q);
  assign pass_end = (scan_q == valid_q) && !rd_vld_q;

  // recent-window membership: age of entry behind the write slot
  logic [AW:0] age_w;
  logic [AW-1:0] age;
  logic recent_hit;
  always_comb begin
    age_w = {1'b0, ws_q} + AW'(D - 1) - {1'b0, rd_idx_q};
    if (age_w >= (AW + 1)'(D)) age_w = age_w - (AW + 1)'(D);
    age        = age_w[AW-1:0];
    recent_hit = {1'b0, age} < s_q;
  end

  // window length clamp
  logic [15:0] s_w;
  always_comb begin
    s_w = (recent_q == 9'd0) ? 16'd1 : 16'(recent_q);
    if (s_w > 16'(valid_q)) s_w = 16'(valid_q);
  end

  // rank from percentile product, divide by 10000 via reciprocal
  logic [KW-1:0] kpct_prod, k99_prod;
  always_comb begin
    kpct_prod = KW'(prod_q) * KW'(fts_pkg::RecipMul);
    k99_prod  = KW'(prod99_q) * KW'(fts_pkg::RecipMul);
  end

  // rank selection compare
  logic [TW:0]   low_m;
  logic [TW-1:0] hi_mask;
  logic          hit_a, hit_b;
  always_comb begin
    low_m   = ((TW + 1)'(2) << bit_q) - 1'b1;
    hi_mask = ~low_m[TW-1:0];
    hit_a   = ((rd_data_q & hi_mask) == (pa_q & hi_mask)) && !rd_data_q[bit_q];
    hit_b   = ((rd_data_q & hi_mask) == (pb_q & hi_mask)) && !rd_data_q[bit_q];
  end

  // shared divider
  logic          div_start, div_busy, div_done;
  logic [NW-1:0] div_num, div_quot;
  logic [TW-1:0] div_den;

  always_comb begin
    case (op_q)
      OP_MEAN:  begin div_num = NW'(sum_q);  div_den = TW'(valid_q); end
      OP_RMEAN: begin div_num = NW'(rsum_q); div_den = TW'(s_q);     end
      default:  begin div_num = NW'(fts_pkg::RateNum); div_den = rmean_q; end
    endcase
  end

  assign div_start = (state_q == S_DIV) && !div_busy && !div_done;

  fts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // result assembly
  fts_pkg::rsp_t rsp;
  logic [1:0]    warn;
  always_comb begin
    if (pb_q > crit_q)        warn = fts_pkg::WARN_CRITICAL;
    else if (mean_q > degr_q) warn = fts_pkg::WARN_DEGRADED;
    else if (max_q > spike_q) warn = fts_pkg::WARN_SPIKE;
    else                      warn = fts_pkg::WARN_NONE;
    rsp = '0;
    if (query_q) begin
      rsp.min_time_us           = min_q;
      rsp.max_time_us           = max_q;
      rsp.mean_time_us          = mean_q;
      rsp.recent_rate_centi_fps = (rmean_q > TW'(1)) ? fts_pkg::RateW'(rate_q)
                                                     : fts_pkg::RateW'(fts_pkg::RateDefault);
      rsp.over_budget_count     = fts_pkg::NumW'(over_q);
      rsp.percentile_time_us    = pa_q;
      rsp.warning_code          = warn;
    end
    rsp.entries_valid = fts_pkg::NumW'(valid_q);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ws_q      <= '0;
      valid_q   <= '0;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      query_q   <= 1'b0;
      op_q      <= OP_MEAN;
      bit_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      rd_idx_q <= scan_q[AW-1:0];
      if (issue) scan_q <= scan_q + 1'b1;
      if (out_vld_q && !out_stall_i && (state_q != S_DONE)) out_vld_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            query_q <= 1'b0;
            scan_q  <= '0;
            state_q <= S_DONE;
            case (in_item_i.req_type)
              fts_pkg::REQ_RECORD: begin
                ws_q <= (ws_q == AW'(D - 1)) ? '0 : ws_q + 1'b1;
                if (valid_q != CW'(D)) valid_q <= valid_q + 1'b1;
              end
              fts_pkg::REQ_CLEAR: begin
                ws_q    <= '0;
                valid_q <= '0;
              end
              fts_pkg::REQ_QUERY: begin
                if (valid_q != '0) begin
                  query_q <= 1'b1;
                  state_q <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (pass_end) begin
            state_q <= S_DIV;
            op_q    <= OP_MEAN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (op_q == OP_RATE) begin
              state_q <= S_SEL;
              bit_q   <= BitCW'(TW - 1);
              scan_q  <= '0;
            end else begin
              op_q <= op_q + 1'b1;
            end
          end
        end
        S_SEL: begin
          if (pass_end) begin
            scan_q <= '0;
            if (bit_q == '0) state_q <= S_DONE;
            else             bit_q   <= bit_q - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_vld_q || !out_stall_i) begin
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_q  <= '1;
      max_q  <= '0;
      sum_q  <= '0;
      rsum_q <= '0;
      over_q <= '0;
      s_q    <= CW'(s_w);
      pct_q  <= (in_item_i.percentile_hundredths > fts_pkg::PctW'(fts_pkg::PctFull)) ?
                fts_pkg::PctW'(fts_pkg::PctFull) : in_item_i.percentile_hundredths;
      pa_q   <= '0;
      pb_q   <= '0;
    end

    // statistics pass
    if (state_q == S_SCAN) begin
      if (rd_vld_q) begin
        if (rd_data_q < min_q) min_q <= rd_data_q;
        if (rd_data_q > max_q) max_q <= rd_data_q;
        sum_q <= sum_q + SW'(rd_data_q);
        if (recent_hit)           rsum_q <= rsum_q + SW'(rd_data_q);
        if (rd_data_q > budget_q) over_q <= over_q + 1'b1;
      end
      if (pass_end) begin
        prod_q   <= PW'(pct_q) * PW'(valid_q - 1'b1);
        prod99_q <= PW'(fts_pkg::PctP99) * PW'(valid_q - 1'b1);
      end
    end

    // divider results; ranks taken with the rate
    if ((state_q == S_DIV) && div_done) begin
      case (op_q)
        OP_MEAN:  mean_q  <= div_quot[TW-1:0];
        OP_RMEAN: rmean_q <= div_quot[TW-1:0];
        default: begin
          rate_q <= div_quot;
          ka_q   <= kpct_prod[fts_pkg::RecipShift +: AW];
          kb_q   <= k99_prod[fts_pkg::RecipShift +: AW];
        end
      endcase
      cnta_q <= '0;
      cntb_q <= '0;
    end

    // bitwise rank selection
    if (state_q == S_SEL) begin
      if (rd_vld_q) begin
        if (hit_a) cnta_q <= cnta_q + 1'b1;
        if (hit_b) cntb_q <= cntb_q + 1'b1;
      end
      if (pass_end) begin
        cnta_q <= '0;
        cntb_q <= '0;
        if (cnta_q <= {1'b0, ka_q}) begin
          ka_q <= ka_q - cnta_q[AW-1:0];
          pa_q <= pa_q | (TW'(1) << bit_q);
        end
        if (cntb_q <= {1'b0, kb_q}) begin
          kb_q <= kb_q - cntb_q[AW-1:0];
          pb_q <= pb_q | (TW'(1) << bit_q);
        end
      end
    end

    if ((state_q == S_DONE) && (!out_vld_q || !out_stall_i)) out_q <= rsp;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ----- src/fts_checker.sv -----
// ----------------------------------------------------------------------------
// fts_checker
// Port-level checks of the frame time window statistics block.
// ----------------------------------------------------------------------------
module fts_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fts_pkg::rsp_t out_item_o
);

  // held result does not move
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // percentile lies between min and max
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.min_time_us <= out_item_o.percentile_time_us) &&
                    (out_item_o.percentile_time_us <= out_item_o.max_time_us))
    else $error("percentile outside min/max");

  // over-budget count bounded by fill
  a_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.over_budget_count <= out_item_o.entries_valid)
    else $error("over-budget count above fill");

  // empty history gives zero statistics
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.entries_valid == '0) |->
      (out_item_o.max_time_us == '0) && (out_item_o.recent_rate_centi_fps == '0) &&
      (out_item_o.warning_code == fts_pkg::WARN_NONE))
    else $error("nonzero statistics on empty history");

endmodule

bind frame_time_window_stats_top fts_checker u_fts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
